/* rtl/core/awci_pkg.sv */
// awci_pkg: shared constants, types and helpers for the arena wall clamp block
// used by awci_frac_div and arena_wall_clamp_intersect; no dependencies
`timescale 1ns / 1ps

package awci_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int Q_W        = FRAC_BITS + 1;   // quotient lies in [0, 1]
	localparam int DIV_STAGES = Q_W;             // one quotient bit per stage
	localparam int MAG_W      = 33;              // magnitude of a 33-bit signed distance
	localparam int SUM_W      = MAG_W + 1;
	localparam int REM_W      = SUM_W + 1;
	localparam int PROD_W     = MAG_W + Q_W;
	localparam int LATENCY    = 5 + DIV_STAGES;  // accept edge to result edge

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Z = 3'd1;
	localparam logic [2:0] REG_HALF_X   = 3'd2;
	localparam logic [2:0] REG_HALF_Z   = 3'd3;

	typedef enum logic [1:0] {
		WALL_PX = 2'd0,
		WALL_NX = 2'd1,
		WALL_PZ = 2'd2,
		WALL_NZ = 2'd3
	} wall_t;

	// sideband that rides along the divider
	typedef struct packed {
		logic [31:0]        clamped_x;
		logic [31:0]        clamped_z;
		logic               collided;
		logic               cross_valid;
		wall_t              code;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
	} side_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v[33:31] != {3{v[33]}}) begin
			r = v[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [MAG_W-1:0] mag33(input logic signed [32:0] v);
		logic [MAG_W-1:0] r;
		r = v[32] ? (~v + 33'd1) : v;
		return r;
	endfunction

endpackage

/* rtl/core/awci_frac_div.sv */
// awci_frac_div: pipelined restoring divider, num * 2^FRAC_BITS / den, one bit per stage
// depends on awci_pkg; carries an awci_pkg::side_t sideband beside each beat
`timescale 1ns / 1ps

module awci_frac_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [awci_pkg::MAG_W-1:0]    in_num,
	input  logic [awci_pkg::SUM_W-1:0]    in_den,
	input  awci_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [awci_pkg::Q_W-1:0]      out_quot,
	output awci_pkg::side_t               out_side
);

	logic                          vld_s  [awci_pkg::DIV_STAGES];
	logic [awci_pkg::REM_W-1:0]    rem_s  [awci_pkg::DIV_STAGES];
	logic [awci_pkg::SUM_W-1:0]    den_s  [awci_pkg::DIV_STAGES];
	logic [awci_pkg::Q_W-1:0]      quot_s [awci_pkg::DIV_STAGES];
	awci_pkg::side_t               side_s [awci_pkg::DIV_STAGES];

	for (genvar k = 0; k < awci_pkg::DIV_STAGES; k++) begin : g_stage
		logic [awci_pkg::REM_W-1:0] r_in;
		logic [awci_pkg::REM_W-1:0] d_ext;
		logic                       bit_q;
		logic [awci_pkg::SUM_W-1:0] den_in;
		logic [awci_pkg::Q_W-1:0]   q_prev;
		logic                       v_in;
		awci_pkg::side_t            side_in;

		if (k == 0) begin : g_first
			// integer bit: the remainder starts as the numerator itself
			assign r_in    = awci_pkg::REM_W'(in_num);
			assign den_in  = in_den;
			assign q_prev  = '0;
			assign v_in    = in_valid;
			assign side_in = in_side;
		end else begin : g_next
			assign r_in    = {rem_s[k-1][awci_pkg::REM_W-2:0], 1'b0};
			assign den_in  = den_s[k-1];
			assign q_prev  = quot_s[k-1];
			assign v_in    = vld_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign d_ext = awci_pkg::REM_W'(den_in);
		assign bit_q = (r_in >= d_ext);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= bit_q ? (r_in - d_ext) : r_in;
			den_s[k]  <= den_in;
			quot_s[k] <= {q_prev[awci_pkg::Q_W-2:0], bit_q};
			side_s[k] <= side_in;
		end
	end

	assign out_valid = vld_s[awci_pkg::DIV_STAGES-1];
	assign out_quot  = quot_s[awci_pkg::DIV_STAGES-1];
	assign out_side  = side_s[awci_pkg::DIV_STAGES-1];

endmodule

/* rtl/core/arena_wall_clamp_intersect.sv */
// arena_wall_clamp_intersect: clamps a point to four arena walls and finds the wall crossing
// depends on awci_pkg and awci_frac_div
// a result beat follows its start beat through stages 1 to 3, the divider, the multiply stage and the output stage
// throughput: one beat per cycle, busy stays low, the pipeline never stalls
// the depth is set by the fraction divider, one quotient bit per stage
// reset: arst_n clears all valid bits and the four registers to zero
`timescale 1ns / 1ps

module arena_wall_clamp_intersect (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               wr_en,
	input  logic [2:0]         wr_idx,
	input  logic [31:0]        wr_data,
	// command side
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] old_x,
	input  logic signed [31:0] old_y,
	input  logic signed [31:0] old_z,
	input  logic               reflect,
	// result side
	output logic               done,
	output logic signed [31:0] clamped_x,
	output logic signed [31:0] clamped_z,
	output logic               collided,
	output logic               crossing_valid,
	output logic signed [31:0] crossing_x,
	output logic signed [31:0] crossing_y,
	output logic signed [31:0] crossing_z,
	output logic [1:0]         wall_code
);

	// configuration registers
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_z_q;
	logic [30:0]        half_x_q;
	logic [30:0]        half_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_z_q <= '0;
			half_x_q   <= '0;
			half_z_q   <= '0;
		end else if (wr_en) begin
			// indexes past the list fall through untouched
			if (wr_idx == awci_pkg::REG_CENTER_X) center_x_q <= wr_data;
			if (wr_idx == awci_pkg::REG_CENTER_Z) center_z_q <= wr_data;
			if (wr_idx == awci_pkg::REG_HALF_X)   half_x_q   <= wr_data[30:0];
			if (wr_idx == awci_pkg::REG_HALF_Z)   half_z_q   <= wr_data[30:0];
		end
	end

	// never stalls
	assign busy = 1'b0;
	logic accept;
	assign accept = start && !busy;

	// ---------------- stage 1: capture beat, saturated wall positions
	logic               vld_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1, ox_s1, oy_s1, oz_s1;
	logic               refl_s1;
	logic signed [31:0] wpx_s1, wnx_s1, wpz_s1, wnz_s1;

	logic signed [33:0] cx_ext, cz_ext, hx_ext, hz_ext;
	assign cx_ext = 34'(center_x_q);
	assign cz_ext = 34'(center_z_q);
	assign hx_ext = $signed({3'b000, half_x_q});
	assign hz_ext = $signed({3'b000, half_z_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= pos_x;
		py_s1   <= pos_y;
		pz_s1   <= pos_z;
		ox_s1   <= old_x;
		oy_s1   <= old_y;
		oz_s1   <= old_z;
		refl_s1 <= reflect;
		wpx_s1  <= awci_pkg::sat32(cx_ext + hx_ext);
		wnx_s1  <= awci_pkg::sat32(cx_ext - hx_ext);
		wpz_s1  <= awci_pkg::sat32(cz_ext + hz_ext);
		wnz_s1  <= awci_pkg::sat32(cz_ext - hz_ext);
	end

	// ---------------- stage 2: wall tests, clamping, pick the candidate crossing
	logic hit_px, hit_nx, hit_pz, hit_nz;
	logic signed [31:0] clx, clz;
	assign hit_px = (wpx_s1 <= px_s1);
	assign hit_nx = !hit_px && (wnx_s1 >= px_s1);
	assign hit_pz = (wpz_s1 <= pz_s1);
	assign hit_nz = !hit_pz && (wnz_s1 >= pz_s1);
	assign clx = hit_px ? wpx_s1 : (hit_nx ? wnx_s1 : px_s1);
	assign clz = hit_pz ? wpz_s1 : (hit_nz ? wnz_s1 : pz_s1);

	logic               vld_s2, refl_s2;
	logic               xhit_s2, zhit_s2, xpos_s2, zpos_s2;
	logic signed [31:0] clx_s2, clz_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2, ox_s2, oy_s2, oz_s2;
	logic signed [31:0] wx_s2, wz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		refl_s2 <= refl_s1;
		xhit_s2 <= hit_px || hit_nx;
		zhit_s2 <= hit_pz || hit_nz;
		xpos_s2 <= hit_px;
		zpos_s2 <= hit_pz;
		clx_s2  <= clx;
		clz_s2  <= clz;
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		pz_s2   <= pz_s1;
		ox_s2   <= ox_s1;
		oy_s2   <= oy_s1;
		oz_s2   <= oz_s1;
		wx_s2   <= hit_px ? wpx_s1 : wnx_s1;
		wz_s2   <= hit_pz ? wpz_s1 : wnz_s1;
	end

	// ---------------- stage 3: distances, divider operands, crossing direction
	logic signed [33:0] dxn, dxo, dzn, dzo;
	assign dxn = 34'(px_s2) - 34'(wx_s2);
	assign dxo = 34'(ox_s2) - 34'(wx_s2);
	assign dzn = 34'(pz_s2) - 34'(wz_s2);
	assign dzo = 34'(oz_s2) - 34'(wz_s2);

	// a wall with both distances zero yields no crossing
	logic xc, zc, use_z;
	assign xc    = xhit_s2 && refl_s2 && !(dxn == '0 && dxo == '0);
	assign zc    = zhit_s2 && refl_s2 && !(dzn == '0 && dzo == '0);
	assign use_z = zc;

	logic [awci_pkg::MAG_W-1:0] an, ao;
	assign an = use_z ? awci_pkg::mag33(dzn[32:0]) : awci_pkg::mag33(dxn[32:0]);
	assign ao = use_z ? awci_pkg::mag33(dzo[32:0]) : awci_pkg::mag33(dxo[32:0]);

	// the z crossing starts from the already clamped x
	logic signed [31:0] cpx;
	assign cpx = use_z ? clx_s2 : px_s2;

	logic                       vld_s3;
	logic [awci_pkg::MAG_W-1:0] num_s3;
	logic [awci_pkg::SUM_W-1:0] den_s3;
	awci_pkg::side_t            side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_s3              <= an;
		den_s3              <= awci_pkg::SUM_W'(an) + awci_pkg::SUM_W'(ao);
		side_s3.clamped_x   <= clx_s2;
		side_s3.clamped_z   <= clz_s2;
		side_s3.collided    <= xhit_s2 || zhit_s2;
		side_s3.cross_valid <= xc || zc;
		side_s3.code        <= use_z ? (zpos_s2 ? awci_pkg::WALL_PZ : awci_pkg::WALL_NZ)
		                             : (xpos_s2 ? awci_pkg::WALL_PX : awci_pkg::WALL_NX);
		side_s3.px          <= cpx;
		side_s3.py          <= py_s2;
		side_s3.pz          <= pz_s2;
		side_s3.dx          <= 33'(ox_s2) - 33'(cpx);
		side_s3.dy          <= 33'(oy_s2) - 33'(py_s2);
		side_s3.dz          <= 33'(oz_s2) - 33'(pz_s2);
	end

	// ---------------- divider: fraction |d| / (|d| + |d_old|)
	logic                     dv_valid;
	logic [awci_pkg::Q_W-1:0] dv_quot;
	awci_pkg::side_t          dv_side;

	awci_frac_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_num    (num_s3),
		.in_den    (den_s3),
		.in_side   (side_s3),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	// ---------------- multiply stage: |diff| * fraction per axis
	logic                          vld_m_q;
	logic [awci_pkg::PROD_W-1:0]   prx_q, pry_q, prz_q;
	awci_pkg::side_t               side_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m_q <= 1'b0;
		end else begin
			vld_m_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		prx_q    <= awci_pkg::PROD_W'(awci_pkg::mag33(dv_side.dx)) * awci_pkg::PROD_W'(dv_quot);
		pry_q    <= awci_pkg::PROD_W'(awci_pkg::mag33(dv_side.dy)) * awci_pkg::PROD_W'(dv_quot);
		prz_q    <= awci_pkg::PROD_W'(awci_pkg::mag33(dv_side.dz)) * awci_pkg::PROD_W'(dv_quot);
		side_m_q <= dv_side;
	end

	// ---------------- output stage: drop fraction bits, step from p toward old
	localparam int STEP_W = awci_pkg::PROD_W - awci_pkg::FRAC_BITS;

	logic [STEP_W-1:0] mx, my, mz;
	assign mx = prx_q[awci_pkg::PROD_W-1:awci_pkg::FRAC_BITS];
	assign my = pry_q[awci_pkg::PROD_W-1:awci_pkg::FRAC_BITS];
	assign mz = prz_q[awci_pkg::PROD_W-1:awci_pkg::FRAC_BITS];

	logic [STEP_W-1:0] rx, ry, rz;
	assign rx = side_m_q.dx[32] ? (STEP_W'(side_m_q.px) - mx) : (STEP_W'(side_m_q.px) + mx);
	assign ry = side_m_q.dy[32] ? (STEP_W'(side_m_q.py) - my) : (STEP_W'(side_m_q.py) + my);
	assign rz = side_m_q.dz[32] ? (STEP_W'(side_m_q.pz) - mz) : (STEP_W'(side_m_q.pz) + mz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_m_q;
		end
	end

	// crossing fields read zero when no crossing was found
	always_ff @(posedge clk) begin
		clamped_x      <= side_m_q.clamped_x;
		clamped_z      <= side_m_q.clamped_z;
		collided       <= side_m_q.collided;
		crossing_valid <= side_m_q.cross_valid;
		crossing_x     <= side_m_q.cross_valid ? rx[31:0] : '0;
		crossing_y     <= side_m_q.cross_valid ? ry[31:0] : '0;
		crossing_z     <= side_m_q.cross_valid ? rz[31:0] : '0;
		wall_code      <= side_m_q.cross_valid ? side_m_q.code : awci_pkg::WALL_PX;
	end

	// ---------------- assertions
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(awci_pkg::LATENCY) done)
		else $error("result beat missing after fixed latency");

	a_cross_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && crossing_valid |-> collided)
		else $error("crossing without a wall hit");

	a_no_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !crossing_valid |-> (wall_code == awci_pkg::WALL_PX) && (crossing_x == '0)
			&& (crossing_y == '0) && (crossing_z == '0))
		else $error("crossing fields not cleared");

	a_div_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid && dv_side.cross_valid |-> dv_quot <= (awci_pkg::Q_W'(1) << awci_pkg::FRAC_BITS))
		else $error("crossing fraction above one");

endmodule
